[rtl/assert_macros.svh]
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is low.
`define TSSR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define TSSR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/tssr_pkg.sv]
`default_nettype none
package tssr_pkg;
  localparam int ROW_COUNT     = 64;
  localparam int COLUMN_COUNT  = 1024;
  localparam int FRACTION_BITS = 16;

  localparam int ROW_W = $clog2(ROW_COUNT);
  localparam int COL_W = $clog2(COLUMN_COUNT);
  localparam int WID_W = $clog2(COLUMN_COUNT + 1);
  localparam int POS_W = COL_W + FRACTION_BITS + 3;
  localparam int NUM_W = ROW_W + COL_W + FRACTION_BITS + 2;
  localparam int CNT_W = $clog2(NUM_W + 1);

  localparam int IN_W    = 3 * (COL_W + ROW_W);
  localparam int IN_PAD  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W   = ROW_W + COL_W + WID_W;
  localparam int OUT_PAD = ((OUT_W + 7) / 8) * 8;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic signed [NUM_W-1:0] num_t;

  typedef struct packed {
    logic             start;
    num_t             num;
    logic [ROW_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    num_t quo;
  } div_rsp_t;

  function automatic pos_t fx(input logic [COL_W-1:0] x);
    return {{(POS_W-COL_W-FRACTION_BITS){1'b0}}, x, {FRACTION_BITS{1'b0}}};
  endfunction

  function automatic num_t sx(input pos_t p);
    return {{(NUM_W-POS_W){p[POS_W-1]}}, p};
  endfunction

  // Truncate an edge to a column and clamp it to 0..COLUMN_COUNT.
  function automatic logic [WID_W-1:0] col_of(input pos_t c);
    pos_t t;
    t = c >>> FRACTION_BITS;
    if (c[POS_W-1]) begin
      return '0;
    end else if (t > pos_t'(COLUMN_COUNT)) begin
      return WID_W'(COLUMN_COUNT);
    end
    return t[WID_W-1:0];
  endfunction
endpackage
`default_nettype wire

[rtl/triangle_scanline_span_rasterizer_unit.sv]
// Triangle span rasterizer.
// The slave stream takes one triangle per transaction: tdata holds vertex a x, a y,
// b x, b y, c x, c y from the lowest bit up. The master stream gives one
// transaction per covered row with row, start column and width in tdata; tuser
// flags a rejected zero-height triangle, and tlast marks the final transaction of
// each triangle.
// One triangle is worked on at a time. After acceptance it takes up to five
// signed divisions on a shared bit-serial divider and gives one span per cycle,
// while the receiver is ready, for each covered row, up to 64; a triangle with
// a split gives its upper rows before its last two divisions. A flat one takes
// two divisions. A zero-height triangle passes through a reject state to its
// single result.
// A stalled receiver holds the output register and freezes the row walk; no
// result is dropped. Reset empties the output register and returns the
// sequencer to idle, ready for a new triangle.
`default_nettype none
module triangle_scanline_span_rasterizer_unit
  import tssr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  // vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y
  input  wire logic [IN_PAD-1:0]  s_tdata,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  // span_row, span_start, span_width, zero pad
  output logic [OUT_PAD-1:0]      m_tdata,
  // rejected
  output logic [0:0]              m_tuser,
  output logic                    m_tlast
);
  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_REJ  = 9'b000000010,
    ST_MID  = 9'b000000100,
    ST_BS1  = 9'b000001000,
    ST_BS2  = 9'b000010000,
    ST_BRUN = 9'b000100000,
    ST_TS1  = 9'b001000000,
    ST_TS2  = 9'b010000000,
    ST_TRUN = 9'b100000000
  } state_t;

  state_t state, state_next;

  logic [COL_W-1:0] vx [3];
  logic [ROW_W-1:0] vy [3];
  logic [1:0]       o0, o1, o2, ot;

  logic [COL_W-1:0] xt, xm, xb;
  logic [ROW_W-1:0] yt, ym, yb, row;
  logic             flat_bot, general, pending;
  pos_t             mx, s1, s2, c1, c2, tp1, tp2, p3;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic signed [ROW_W:0]           dyy;
  logic signed [COL_W:0]           dxx;
  logic signed [ROW_W+COL_W+1:0]   prod;
  logic                            slot;
  logic [WID_W-1:0]                ca, cb, cmin, cwid;
  logic [COL_W-1:0]                cstart;
  logic                            div_state;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vx[i] = s_tdata[i*(COL_W+ROW_W) +: COL_W];
      vy[i] = s_tdata[i*(COL_W+ROW_W)+COL_W +: ROW_W];
    end
    o0 = 2'd0;
    o1 = 2'd1;
    o2 = 2'd2;
    ot = 2'd0;
    for (int p = 0; p < 2; p++) begin
      if (vy[o0] > vy[o1]) begin
        ot = o0; o0 = o1; o1 = ot;
      end
      if (vy[o1] > vy[o2]) begin
        ot = o1; o1 = o2; o2 = ot;
      end
    end
  end

  assign s_tready = state == ST_IDLE;
  assign slot     = !m_tvalid || m_tready;

  assign tp1 = general ? fx(xm) : fx(xt);
  assign tp2 = general ? mx : fx(xm);
  assign p3  = flat_bot ? fx(xb) : mx;

  function automatic logic signed [ROW_W+COL_W+1:0] dyy_mid();
    return (ROW_W+COL_W+2)'(signed'({1'b0, ROW_W'(ym - yt)}));
  endfunction

  assign dyy  = signed'({1'b0, ROW_W'(yb - yt)});
  assign dxx  = signed'({1'b0, xb}) - signed'({1'b0, xt});
  assign prod = dyy_mid() * dxx;

  assign div_state = state == ST_MID || state == ST_BS1 || state == ST_BS2 ||
                     state == ST_TS1 || state == ST_TS2;

  always_comb begin
    div_req.start = div_state && !pending;
    div_req.num   = '0;
    div_req.den   = ROW_W'(ym - yt);
    case (state)
      ST_MID: begin
        div_req.num = {prod, {FRACTION_BITS{1'b0}}};
        div_req.den = dyy[ROW_W-1:0];
      end
      ST_BS1: div_req.num = sx(fx(xm)) - sx(fx(xt));
      ST_BS2: div_req.num = sx(p3) - sx(fx(xt));
      ST_TS1: begin
        div_req.num = sx(fx(xb)) - sx(tp1);
        div_req.den = ROW_W'(yb - ym);
      end
      ST_TS2: begin
        div_req.num = sx(fx(xb)) - sx(tp2);
        div_req.den = ROW_W'(yb - ym);
      end
      default: div_req.num = '0;
    endcase
  end

  tssr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign ca     = col_of(c1);
  assign cb     = col_of(c2);
  assign cmin   = (ca < cb) ? ca : cb;
  assign cwid   = (ca < cb) ? cb - ca : ca - cb;
  assign cstart = (cmin > WID_W'(COLUMN_COUNT - 1)) ? COL_W'(COLUMN_COUNT - 1)
                                                     : cmin[COL_W-1:0];

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (vy[o0] == vy[o2]) begin
            state_next = ST_REJ;
          end else if (vy[o1] == vy[o2]) begin
            state_next = ST_BS1;
          end else if (vy[o0] == vy[o1]) begin
            state_next = ST_TS1;
          end else begin
            state_next = ST_MID;
          end
        end
      end
      ST_REJ:  if (slot) state_next = ST_IDLE;
      ST_MID:  if (div_rsp.done) state_next = ST_BS1;
      ST_BS1:  if (div_rsp.done) state_next = ST_BS2;
      ST_BS2:  if (div_rsp.done) state_next = ST_BRUN;
      ST_BRUN: if (slot && row == ym) state_next = flat_bot ? ST_IDLE : ST_TS1;
      ST_TS1:  if (div_rsp.done) state_next = ST_TS2;
      ST_TS2:  if (div_rsp.done) state_next = ST_TRUN;
      ST_TRUN: if (slot && row == ROW_W'(ym + 1'b1)) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pending  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (div_rsp.done) begin
        pending <= 1'b0;
      end else if (div_req.start) begin
        pending <= 1'b1;
      end
      if ((state == ST_REJ || state == ST_BRUN || state == ST_TRUN) && slot) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      xt       <= vx[o0];
      yt       <= vy[o0];
      xm       <= vx[o1];
      ym       <= vy[o1];
      xb       <= vx[o2];
      yb       <= vy[o2];
      flat_bot <= vy[o1] == vy[o2];
      general  <= vy[o0] != vy[o1] && vy[o1] != vy[o2];
    end
    if (div_rsp.done) begin
      case (state)
        ST_MID: mx <= pos_t'(div_rsp.quo) + fx(xt);
        ST_BS1: s1 <= pos_t'(div_rsp.quo);
        ST_BS2: begin
          s2  <= pos_t'(div_rsp.quo);
          c1  <= fx(xt);
          c2  <= fx(xt) + pos_t'(1 << FRACTION_BITS);
          row <= yt;
        end
        ST_TS1: s1 <= pos_t'(div_rsp.quo);
        ST_TS2: begin
          s2  <= pos_t'(div_rsp.quo);
          c1  <= fx(xb) - pos_t'(1 << FRACTION_BITS);
          c2  <= fx(xb);
          row <= yb;
        end
        default: mx <= mx;
      endcase
    end
    if (slot) begin
      case (state)
        ST_REJ: begin
          m_tdata <= '0;
          m_tuser <= 1'b1;
          m_tlast <= 1'b1;
        end
        ST_BRUN: begin
          m_tdata <= OUT_PAD'({cwid, cstart, row});
          m_tuser <= 1'b0;
          m_tlast <= flat_bot && row == ym;
          row     <= row + 1'b1;
          c1      <= c1 + s1;
          c2      <= c2 + s2;
        end
        ST_TRUN: begin
          m_tdata <= OUT_PAD'({cwid, cstart, row});
          m_tuser <= 1'b0;
          m_tlast <= row == ROW_W'(ym + 1'b1);
          row     <= row - 1'b1;
          c1      <= c1 - s1;
          c2      <= c2 - s2;
        end
        default: m_tuser <= m_tuser;
      endcase
    end
  end
endmodule
`default_nettype wire

[rtl/tssr_div.sv]
`default_nettype none
module tssr_div
  import tssr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);
  logic [NUM_W-1:0] mag;
  logic [ROW_W-1:0] rem;
  logic [ROW_W-1:0] den;
  logic [CNT_W-1:0] cnt;
  logic             neg;
  logic             busy;
  logic [ROW_W:0]   trial;
  logic             fits;

  assign trial = {rem, mag[NUM_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        den  <= req.den;
        neg  <= req.num[NUM_W-1];
        mag  <= req.num[NUM_W-1] ? NUM_W'(-req.num) : req.num;
      end else if (busy) begin
        rem <= fits ? ROW_W'(trial - {1'b0, den}) : trial[ROW_W-1:0];
        mag <= {mag[NUM_W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy     <= 1'b0;
          rsp.done <= 1'b1;
          rsp.quo  <= neg ? -num_t'({mag[NUM_W-2:0], fits})
                          : num_t'({mag[NUM_W-2:0], fits});
        end
      end
    end
  end
endmodule
`default_nettype wire

[rtl/tssr_checker.sv]
`default_nettype none
`include "assert_macros.svh"
module tssr_checker
  import tssr_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               s_tvalid,
  input wire logic               s_tready,
  input wire logic               m_tvalid,
  input wire logic               m_tready,
  input wire logic [OUT_PAD-1:0] m_tdata,
  input wire logic [0:0]         m_tuser,
  input wire logic               m_tlast
);
  `TSSR_ASSERT(a_stall_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output changed while stalled")
  `TSSR_ASSERT(a_reject_form, m_tvalid && m_tuser[0] |-> m_tlast && m_tdata == '0, "rejected transaction malformed")
  `TSSR_ASSERT(a_one_at_a_time, s_tvalid && s_tready |=> !s_tready, "second triangle accepted while busy")
  `TSSR_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !m_tvalid, "output valid right after reset")
endmodule

bind triangle_scanline_span_rasterizer_unit tssr_checker u_tssr_checker (.*);
`default_nettype wire

[test/tb_triangle_scanline_span_rasterizer_unit.sv]
`default_nettype none
module tb_triangle_scanline_span_rasterizer_unit;
  import tssr_pkg::*;

  typedef struct packed {
    logic [ROW_W-1:0] cy;
    logic [COL_W-1:0] cx;
    logic [ROW_W-1:0] by;
    logic [COL_W-1:0] bx;
    logic [ROW_W-1:0] ay;
    logic [COL_W-1:0] ax;
  } triangle_t;

  typedef struct {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] start;
    logic [WID_W-1:0] width;
    logic             rejected;
    logic             last;
  } span_t;

  typedef struct {
    triangle_t trgl;
    bit        typed_reject;
  } row_t;

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [IN_PAD-1:0]  s_tdata;
  logic               m_tvalid;
  logic               m_tready;
  logic [OUT_PAD-1:0] m_tdata;
  logic [0:0]         m_tuser;
  logic               m_tlast;

  span_t span_queue[$];
  int    error_count = 0;

  triangle_scanline_span_rasterizer_unit i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic triangle_t mk(int ax, int ay, int bx, int by, int cx, int cy);
    triangle_t t;
    t.ax = COL_W'(ax); t.ay = ROW_W'(ay);
    t.bx = COL_W'(bx); t.by = ROW_W'(by);
    t.cx = COL_W'(cx); t.cy = ROW_W'(cy);
    return t;
  endfunction

  function automatic longint edge_col(longint v);
    longint c;
    c = (v < 0) ? -((-v) >>> FRACTION_BITS) : (v >>> FRACTION_BITS);
    if (c < 0) c = 0;
    if (c > COLUMN_COUNT) c = COLUMN_COUNT;
    return c;
  endfunction

  function automatic void add_span(ref span_t q[$], input longint row, longint e1,
                                   longint e2);
    longint a, b, st;
    span_t s;
    if (q.size() >= ROW_COUNT) return;
    a = edge_col(e1);
    b = edge_col(e2);
    st = (a < b) ? a : b;
    s.width = WID_W'((a < b) ? b - a : a - b);
    if (st > COLUMN_COUNT - 1) st = COLUMN_COUNT - 1;
    s.start = COL_W'(st);
    s.row = ROW_W'(row);
    s.rejected = 1'b0;
    s.last = 1'b0;
    q = {q, s};
  endfunction

  function automatic void walk_down(ref span_t q[$], input longint p1, longint y1,
                                    longint p2, longint y2, longint p3);
    longint dy, s1, s2, c1, c2;
    dy = y2 - y1;
    if (dy <= 0) return;
    s1 = (p2 - p1) / dy;
    s2 = (p3 - p1) / dy;
    c1 = p1;
    c2 = p1 + (longint'(1) << FRACTION_BITS);
    for (longint r = y1; r <= y2; r++) begin
      add_span(q, r, c1, c2);
      c1 += s1;
      c2 += s2;
    end
  endfunction

  function automatic void walk_up(ref span_t q[$], input longint p1, longint p2,
                                  longint y1, longint p3, longint y3);
    longint dy, s1, s2, c1, c2;
    dy = y3 - y1;
    if (dy <= 0) return;
    s1 = (p3 - p1) / dy;
    s2 = (p3 - p2) / dy;
    c1 = p3 - (longint'(1) << FRACTION_BITS);
    c2 = p3;
    for (longint r = y3; r > y1; r--) begin
      add_span(q, r, c1, c2);
      c1 -= s1;
      c2 -= s2;
    end
  endfunction

  function automatic void predict_spans(triangle_t t);
    longint vx[3], vy[3], one, xt, yt, xm, ym, xb, yb, mx;
    int ord[3], tmp;
    span_t q[$];
    span_t s;
    one = longint'(1) << FRACTION_BITS;
    vx[0] = t.ax; vy[0] = t.ay;
    vx[1] = t.bx; vy[1] = t.by;
    vx[2] = t.cx; vy[2] = t.cy;
    ord = '{0, 1, 2};
    repeat (2) begin
      for (int i = 0; i < 2; i++) begin
        if (vy[ord[i]] > vy[ord[i+1]]) begin
          tmp = ord[i]; ord[i] = ord[i+1]; ord[i+1] = tmp;
        end
      end
    end
    xt = vx[ord[0]]; yt = vy[ord[0]];
    xm = vx[ord[1]]; ym = vy[ord[1]];
    xb = vx[ord[2]]; yb = vy[ord[2]];
    if (yt == yb) begin
      s = '{row: 0, start: 0, width: 0, rejected: 1'b1, last: 1'b1};
      span_queue = {span_queue, s};
      return;
    end
    if (ym == yb) begin
      walk_down(q, xt * one, yt, xm * one, ym, xb * one);
    end else if (yt == ym) begin
      walk_up(q, xt * one, xm * one, yt, xb * one, yb);
    end else begin
      mx = xt * one + ((ym - yt) * (xb - xt) * one) / (yb - yt);
      walk_down(q, xt * one, yt, xm * one, ym, mx);
      walk_up(q, xm * one, mx, ym, xb * one, yb);
    end
    q[q.size()-1].last = 1'b1;
    span_queue = {span_queue, q};
  endfunction

  always @(posedge clk) begin
    span_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.row = m_tdata[ROW_W-1:0];
      got.start = m_tdata[ROW_W +: COL_W];
      got.width = m_tdata[ROW_W+COL_W +: WID_W];
      got.rejected = m_tuser[0];
      got.last = m_tlast;
      if (span_queue.size() == 0) begin
        $error("unexpected transaction row=%0d start=%0d width=%0d",
               got.row, got.start, got.width);
        error_count++;
      end else begin
        want = span_queue.pop_front();
        if (got.row !== want.row) begin
          $error("span_row expected %0d actual %0d", want.row, got.row);
          error_count++;
        end
        if (got.start !== want.start) begin
          $error("span_start expected %0d actual %0d", want.start, got.start);
          error_count++;
        end
        if (got.width !== want.width) begin
          $error("span_width expected %0d actual %0d", want.width, got.width);
          error_count++;
        end
        if (got.rejected !== want.rejected) begin
          $error("rejected expected %0d actual %0d", want.rejected, got.rejected);
          error_count++;
        end
        if (got.last !== want.last) begin
          $error("last_span expected %0d actual %0d", want.last, got.last);
          error_count++;
        end
      end
    end
  end

  // Receiver stall pattern: switches at random between always ready, a repeating pattern and random ready.
  int stall_mode = 0;
  int stall_cnt = 0;
  always @(negedge clk) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 400 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= (stall_cnt % 5) > 1;
      default: m_tready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic send(triangle_t t, bit typed_reject);
    span_t rej;
    s_tvalid <= 1'b1;
    s_tdata <= t;
    do @(posedge clk); while (!s_tready);
    if (typed_reject) begin
      rej = '{row: 0, start: 0, width: 0, rejected: 1'b1, last: 1'b1};
      span_queue = {span_queue, rej};
    end else begin
      predict_spans(t);
    end
    @(negedge clk);
  endtask

  int burst_left = 0;
  task automatic pace();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  function automatic triangle_t random_triangle();
    int h, top, bot, mid, kind, tmp, j;
    int ys[3];
    int xs[3];
    kind = $urandom_range(0, 9);
    h = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 63) : $urandom_range(1, 12);
    top = $urandom_range(0, 63 - h);
    bot = top + h;
    mid = $urandom_range(top, bot);
    case (kind)
      0: ys = '{top, top, top};
      1: ys = '{top, bot, bot};
      2: ys = '{top, top, bot};
      default: ys = '{top, mid, bot};
    endcase
    for (int i = 2; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = ys[i]; ys[i] = ys[j]; ys[j] = tmp;
    end
    foreach (xs[i]) begin
      case ($urandom_range(0, 9))
        0: xs[i] = 0;
        1: xs[i] = COLUMN_COUNT - 1;
        default: xs[i] = $urandom_range(0, COLUMN_COUNT - 1);
      endcase
    end
    return mk(xs[0], ys[0], xs[1], ys[1], xs[2], ys[2]);
  endfunction

  row_t directed_rows[$];

  initial begin
    directed_rows = '{
      '{mk(0, 0, 0, 0, 0, 0), 1'b1},
      '{mk(1023, 63, 0, 63, 512, 63), 1'b1},
      '{mk(5, 20, 900, 20, 300, 20), 1'b1},
      '{mk(10, 0, 20, 0, 15, 0), 1'b1},
      '{mk(0, 0, 1023, 63, 0, 63), 1'b0},
      '{mk(1023, 0, 0, 63, 1023, 63), 1'b0},
      '{mk(0, 0, 1023, 0, 512, 63), 1'b0},
      '{mk(0, 63, 1023, 63, 512, 0), 1'b0},
      '{mk(1023, 0, 1023, 63, 1023, 30), 1'b0},
      '{mk(0, 10, 0, 11, 0, 12), 1'b0},
      '{mk(100, 5, 50, 9, 200, 5), 1'b0},
      '{mk(100, 9, 50, 5, 200, 9), 1'b0},
      '{mk(300, 40, 100, 40, 200, 10), 1'b0},
      '{mk(10, 3, 500, 20, 1000, 60), 1'b0},
      '{mk(1000, 60, 500, 20, 10, 3), 1'b0},
      '{mk(700, 12, 20, 33, 1023, 50), 1'b0},
      '{mk(1023, 62, 1022, 63, 1023, 63), 1'b0},
      '{mk(0, 1, 1, 0, 0, 0), 1'b0},
      '{mk(341, 21, 682, 42, 1023, 63), 1'b0},
      '{mk(512, 0, 0, 32, 1023, 63), 1'b0}
    };
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    foreach (directed_rows[i]) begin
      pace();
      send(directed_rows[i].trgl, directed_rows[i].typed_reject);
    end
    for (int n = 0; n < 210; n++) begin
      if (n == 105) begin
        s_tvalid <= 1'b0;
        while (span_queue.size() != 0) @(negedge clk);
      end
      pace();
      send(random_triangle(), 1'b0);
    end
    s_tvalid <= 1'b0;
    while (span_queue.size() != 0) @(negedge clk);
    repeat (300) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
`default_nettype wire

[sim.f]
+incdir+rtl
rtl/tssr_pkg.sv
rtl/tssr_div.sv
rtl/triangle_scanline_span_rasterizer_unit.sv
rtl/tssr_checker.sv
test/tb_triangle_scanline_span_rasterizer_unit.sv
